// ----- hw/rtl/s2da_pkg.sv -----
// Shared constants, types and helper functions for the signed-to-decimal text converter.
// No dependencies; every module of the block imports this package.
package s2da_pkg;

  // Width of the integer being converted; the input port is always 64 bits.
  localparam int VALUE_BITS = 64;
  localparam int IN_BITS    = 64;
  localparam int CHAR_BITS  = 6;

  // ASCII codes as they leave the block.
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

  // Number of decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int              n;
    v = 64'd1 << (bits - 1);
    n = 1;
    while (v >= 64'd10) begin
      v = v / 64'd10;
      n++;
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = dec_digits(VALUE_BITS);
  localparam int BCD_BITS   = 4 * NUM_DIGITS;
  localparam int CNT_BITS   = $clog2(NUM_DIGITS + 1);
  localparam int DIG_IDX    = $clog2(NUM_DIGITS);

  // The converter consumes two magnitude bits per cycle.
  localparam int STEPS     = (VALUE_BITS + 1) / 2;
  localparam int PAD_BITS  = 2 * STEPS;
  localparam int STEP_BITS = $clog2(STEPS);

  // Depth of the queue between the front and the converter.
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // Classified item: sign flag and unsigned magnitude.
  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  // Converted item handed from the converter to the emitter.
  typedef struct packed {
    logic                neg;
    bcd_t                bcd;
    logic [CNT_BITS-1:0] cnt;
  } conv_res_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } cv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGIT
  } em_state_t;

  // One shift-and-add-3 step: correct every digit, then shift in one bit.
  function automatic bcd_t dabble(input bcd_t b, input logic bit_in);
    bcd_t                adj;
    logic [BCD_BITS-1:0] flat;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    flat = adj;
    return {flat[BCD_BITS-2:0], bit_in};
  endfunction

endpackage

// ----- hw/rtl/s2da_front.sv -----
// Front end: accepts input items, keeps the low VALUE_BITS bits and splits them
// into sign and magnitude. Depends on s2da_pkg.
module s2da_front import s2da_pkg::*; (
  input  logic               in_push,
  input  logic [IN_BITS-1:0] in_value,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  logic [VALUE_BITS-1:0] v;

  // Accept whenever the queue has room.
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Sign and magnitude; the most negative value negates to 2^(VALUE_BITS-1) exactly.
  assign v          = in_value[VALUE_BITS-1:0];
  assign q_item.neg = v[VALUE_BITS-1];
  assign q_item.mag = v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;

endmodule

// ----- hw/rtl/s2da_queue.sv -----
// Short queue of classified items between the front end and the converter.
// Depends on s2da_pkg.
module s2da_queue import s2da_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t rd_item
);

  item_t                mem_r [QUEUE_DEPTH];
  logic [QIDX_BITS-1:0] wptr_r, wptr_nxt;
  logic [QIDX_BITS-1:0] rptr_r, rptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/s2da_conv.sv -----
// Converter: turns a magnitude into packed decimal digits by shift-and-add-3,
// two bits per cycle, and counts the significant digits. Depends on s2da_pkg.
module s2da_conv import s2da_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  item_t     q_item,
  output logic      q_pop,
  output logic      res_valid,
  output conv_res_t res,
  input  logic      res_take
);

  cv_state_t            state_r, state_nxt;
  logic [PAD_BITS-1:0]  sh_r;
  bcd_t                 bcd_r, bcd_step;
  logic [CNT_BITS-1:0]  cnt_r, cnt_step;
  logic [STEP_BITS-1:0] step_r;
  logic                 neg_r;
  logic                 load, run, last_step;

  assign last_step = (step_r == STEP_BITS'(STEPS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE:  if (!q_empty)  state_nxt = CV_RUN;
      CV_RUN:   if (last_step) state_nxt = CV_DONE;
      CV_DONE:  if (res_take)  state_nxt = CV_IDLE;
      default:  state_nxt = CV_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load      = 1'b0;
    run       = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      CV_IDLE:  load      = !q_empty;
      CV_RUN:   run       = 1'b1;
      CV_DONE:  res_valid = 1'b1;
      default:  ;
    endcase
  end

  assign q_pop = load;

  // Two dabble steps per cycle. The value at most quadruples plus three per cycle,
  // so the digit count grows by at most one and only the next digit needs a look.
  always_comb begin
    bcd_step = dabble(dabble(bcd_r, sh_r[PAD_BITS-1]), sh_r[PAD_BITS-2]);
    cnt_step = cnt_r;
    if (cnt_r < CNT_BITS'(NUM_DIGITS)) begin
      if (bcd_step[cnt_r[DIG_IDX-1:0]] != 4'd0) begin
        cnt_step = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (load) begin
      sh_r   <= PAD_BITS'(q_item.mag);
      neg_r  <= q_item.neg;
      bcd_r  <= '0;
      cnt_r  <= CNT_BITS'(1);
      step_r <= '0;
    end else if (run) begin
      sh_r   <= {sh_r[PAD_BITS-3:0], 2'b00};
      bcd_r  <= bcd_step;
      cnt_r  <= cnt_step;
      step_r <= step_r + 1'b1;
    end
  end

  assign res.neg = neg_r;
  assign res.bcd = bcd_r;
  assign res.cnt = cnt_r;

endmodule

// ----- hw/rtl/s2da_emit.sv -----
// Emitter: streams the minus sign and the significant digits of one converted
// item into a registered output stage. Depends on s2da_pkg.
module s2da_emit import s2da_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  conv_res_t            res,
  output logic                 res_take,
  output logic                 out_empty,
  output logic [CHAR_BITS-1:0] out_character,
  output logic                 out_last,
  input  logic                 out_pop
);

  em_state_t            state_r, state_nxt;
  bcd_t                 dig_r;
  logic [DIG_IDX-1:0]   pos_r;
  logic                 ov_r, ov_nxt;
  logic [CHAR_BITS-1:0] oc_r;
  logic                 ol_r;
  logic                 adv, produce, chr_last, pos_zero;
  logic [CHAR_BITS-1:0] chr;

  // The output stage can take a new item when empty or being drained.
  assign adv      = !ov_r || out_pop;
  assign pos_zero = (pos_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (res_valid) state_nxt = res.neg ? EM_SIGN : EM_DIGIT;
      end
      EM_SIGN: begin
        if (adv) state_nxt = EM_DIGIT;
      end
      EM_DIGIT: begin
        if (adv && pos_zero) state_nxt = EM_IDLE;
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    res_take = 1'b0;
    produce  = 1'b0;
    chr      = CHAR_ZERO;
    chr_last = 1'b0;
    case (state_r)
      EM_IDLE: begin
        res_take = res_valid;
      end
      EM_SIGN: begin
        produce = adv;
        chr     = CHAR_MINUS;
      end
      EM_DIGIT: begin
        produce  = adv;
        chr      = CHAR_ZERO + {{(CHAR_BITS - 4){1'b0}}, dig_r[pos_r]};
        chr_last = pos_zero;
      end
      default: ;
    endcase
  end

  assign ov_nxt = produce ? 1'b1 : (out_pop ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Digit store, position counter and output payload.
  always_ff @(posedge clk) begin
    if (res_take) begin
      dig_r <= res.bcd;
      pos_r <= DIG_IDX'(res.cnt - CNT_BITS'(1));
    end else if (produce && state_r == EM_DIGIT && !pos_zero) begin
      pos_r <= pos_r - 1'b1;
    end
    if (produce) begin
      oc_r <= chr;
      ol_r <= chr_last;
    end
  end

  assign out_empty     = !ov_r;
  assign out_character = oc_r;
  assign out_last      = ol_r;

endmodule

// ----- hw/rtl/signed_to_decimal_ascii_core.sv -----
// Top level of the signed-to-decimal text converter: front end, item queue,
// converter and emitter. Depends on s2da_pkg and the s2da_* modules.
//
//   channel  | ports                           | flow
//   ---------+---------------------------------+---------------------------------
//   input    | in_push, in_full, in_value      | one signed integer per item
//   result   | out_pop, out_empty,             | one character per item, oldest
//            | out_character, out_last         | first, last set on final one
//
// The converter's shift-and-add-3 loop takes two magnitude bits per cycle. The emitter
// sends one character per cycle while the output stage is not stalled, up to 20 per
// item, while the converter works on the next item.
// Synchronous active-low reset empties the queue and the output stage.
// Either side may stall; the two-entry queue and the converter's hand-off
// register let the front end keep accepting while results wait.
module signed_to_decimal_ascii_core import s2da_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [IN_BITS-1:0]   in_value,
  output logic                 in_full,
  output logic                 out_empty,
  output logic [CHAR_BITS-1:0] out_character,
  output logic                 out_last,
  input  logic                 out_pop
);

  logic      q_full, q_push, q_empty, q_pop;
  item_t     q_wr_item, q_rd_item;
  logic      res_valid, res_take;
  conv_res_t res;

  // Accept and classify.
  s2da_front u_front (
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wr_item)
  );

  // Decouple front end and converter.
  s2da_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  // Binary to packed decimal.
  s2da_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Character stream out.
  s2da_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take),
    .out_empty     (out_empty),
    .out_character (out_character),
    .out_last      (out_last),
    .out_pop       (out_pop)
  );

endmodule

// ----- test/s2da_checker.sv -----
// Scoreboard for the signed-to-decimal text converter: predicts the characters of each
// accepted value and compares them with the characters the block hands out.
// Depends on s2da_pkg for widths and character codes.
module s2da_checker import s2da_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [IN_BITS-1:0]   in_value,
  input  logic                 out_pop,
  input  logic                 out_empty,
  input  logic [CHAR_BITS-1:0] out_character,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending,
  output int                   values_seen,
  output int                   chars_seen,
  output int                   negatives_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              MAX_DIGITS = 20;
  localparam logic [63:0]     RADIX      = 64'd10;

  // One predicted character, tagged with the value it came from.
  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 last;
    logic [IN_BITS-1:0]   src;
  } text_char_t;

  text_char_t text_q [$];
  text_char_t exp_c;

  initial begin
    fail_count     = 0;
    pending        = 0;
    values_seen    = 0;
    chars_seen     = 0;
    negatives_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Expected text of one value: optional minus sign, then digits without leading zeros.
  task automatic expand_to_text(input logic [IN_BITS-1:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic        neg;
    logic [3:0]  dig [MAX_DIGITS];
    int          nd;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    v    = 64'(raw) & mask;
    neg  = v[VALUE_BITS-1];
    // The most negative value negates to itself, which is the right magnitude unsigned.
    mag  = neg ? ((~v + 64'd1) & mask) : v;
    nd   = 0;
    do begin
      dig[nd] = 4'(mag % RADIX);
      mag     = mag / RADIX;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (neg) begin
      text_q.push_back('{CHAR_MINUS, 1'b0, raw});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      text_q.push_back('{CHAR_ZERO + CHAR_BITS'(dig[i]), (i == 0), raw});
    end
  endtask

  // Results are checked before the new item is expanded; a character can never
  // belong to an item accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        chars_seen++;
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("character %0d arrived with nothing expected",
                                    out_character));
        end else begin
          exp_c = text_q.pop_front();
          if (out_character != exp_c.code) begin
            report_mismatch($sformatf("value %0d: character %0d, expected %0d",
                                      $signed(exp_c.src), out_character, exp_c.code));
          end
          if (out_last != exp_c.last) begin
            report_mismatch($sformatf("value %0d: last %0b, expected %0b",
                                      $signed(exp_c.src), out_last, exp_c.last));
          end
        end
      end
      if (in_push && !in_full) begin
        values_seen++;
        if (in_value[VALUE_BITS-1]) begin
          negatives_seen++;
        end
        expand_to_text(in_value);
      end
      pending = text_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the signed-to-decimal text converter: clock, reset, stimulus,
// result draining and the verdict. Depends on s2da_pkg, the block and s2da_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s2da_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int N_RANDOM     = 250;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 100;
  localparam int PAUSE_AT     = 180;
  localparam int CALM_FROM    = 200;
  localparam int CALM_TO      = 230;
  localparam int N_DIR        = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic [IN_BITS-1:0]   in_value;
  logic                 in_full;
  logic                 out_empty;
  logic [CHAR_BITS-1:0] out_character;
  logic                 out_last;
  logic                 out_pop;

  int fail_count;
  int pending;
  int values_seen;
  int chars_seen;
  int negatives_seen;
  int idle_cycles;
  bit hold_req;
  bit no_idle;

  // Zero, small numbers, digit-count boundaries, 32-bit and 64-bit extremes, bit patterns.
  longint dir_vals [N_DIR] = '{
    64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, 64'sd99, -64'sd100,
    64'sd2147483647, -64'sd2147483648, 64'sd4294967295,
    64'sd999999999999999999, 64'sd1000000000000000000, -64'sd1000000000000000000,
    64'sh7fff_ffff_ffff_ffff, 64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0001,
    64'sh5555_5555_5555_5555, 64'shaaaa_aaaa_aaaa_aaaa, -64'sd1234567890
  };

  signed_to_decimal_ascii_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_value      (in_value),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_character (out_character),
    .out_last      (out_last),
    .out_pop       (out_pop)
  );

  s2da_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_value       (in_value),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_character  (out_character),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .values_seen    (values_seen),
    .chars_seen     (chars_seen),
    .negatives_seen (negatives_seen)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random value: full-width patterns, random magnitudes, or powers of ten and their neighbors.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    int          r;
    int          w;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = {$urandom, $urandom};
    end else if (r < 8) begin
      w = $urandom_range(1, 63);
      v = {$urandom, $urandom} >> (64 - w);
      if ($urandom_range(0, 1)) begin
        v = -v;
      end
    end else begin
      p = 64'd1;
      repeat ($urandom_range(1, 19)) p = p * 64'd10;
      v = p - 64'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        v = -v;
      end
    end
    return v;
  endfunction

  // Offer one item from a falling edge and hold it until a rising edge accepts it.
  task automatic push_item(input logic [63:0] v);
    in_push  <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int g;
    g = idle_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Receiver: bursts of pops with random gaps, plus one long hold-off on request.
  initial begin
    int run;
    int g;
    out_pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      run = $urandom_range(1, 20);
      out_pop <= 1'b1;
      repeat (run) @(negedge clk);
      g = idle_len();
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Stimulus: directed values, then random values with a fill phase, a full drain
  // and a stretch without gaps.
  initial begin
    rst_n    = 1'b0;
    in_push  = 1'b0;
    in_value = '0;
    hold_req = 1'b0;
    no_idle  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_vals[i]) begin
      push_item(dir_vals[i]);
      sender_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_AT) begin
        hold_req = 1'b1;
      end
      no_idle = (n >= CALM_FROM && n < CALM_TO) || (n >= HOLD_AT && n < HOLD_AT + 30);
      // Let every outstanding character come out before going on.
      if (n == PAUSE_AT) begin
        in_push <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      push_item(pick_value());
      sender_gap();
    end
    in_push <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative) into %0d characters, including zero,",
             values_seen, negatives_seen, chars_seen);
    $display("both 64-bit extremes, digit-count boundaries, a %0d-cycle hold-off and a full drain.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
